@@ hdl/wfpw_pkg.sv @@
// Shared types and constants for the windowed frame-store pixel writer.
// Holds the request kind codes, register indexes, back-end operation codes and queue types.
// Depends on nothing; the front end, queue, back end, top level and bench import it.
`default_nettype none

package wfpw_pkg;

	localparam int MAX_COLUMNS_DEF = 128;
	localparam int MAX_ROWS_DEF    = 64;
	localparam int STORE_BYTES_DEF = 16384;

	localparam int QUEUE_DEPTH = 4;
	localparam int ENTRY_AW    = 16;

	localparam logic [1:0] KIND_SET_WINDOW = 2'd0;
	localparam logic [1:0] KIND_WRITE      = 2'd1;
	localparam logic [1:0] KIND_SKIP       = 2'd2;
	localparam logic [1:0] KIND_READ       = 2'd3;

	localparam logic [1:0] DEPTH_1BIT  = 2'd0;
	localparam logic [1:0] DEPTH_8BIT  = 2'd1;
	localparam logic [1:0] DEPTH_16BIT = 2'd2;

	localparam logic [1:0] REG_PIXEL_DEPTH = 2'd0;
	localparam logic [1:0] REG_X_LAST      = 2'd1;
	localparam logic [1:0] REG_Y_LAST      = 2'd2;

	localparam logic [1:0] PIXEL_DEPTH_RST = DEPTH_16BIT;
	localparam logic [6:0] X_LAST_RST      = 7'd127;
	localparam logic [5:0] Y_LAST_RST      = 6'd63;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_BYTE,
		OP_PAIR,
		OP_BIT,
		OP_READ
	} op_t;

	typedef struct packed {
		op_t                 op;
		logic [ENTRY_AW-1:0] addr;
		logic [7:0]          data0;
		logic [7:0]          data1;
		logic                en1;
		logic                bit_set;
		logic [6:0]          next_x;
		logic [5:0]          next_y;
	} q_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

`default_nettype wire

@@ hdl/windowed_framebuffer_pixel_writer_unit.sv @@
// Windowed frame-store pixel writer, top level; depends on wfpw_pkg, wfpw_front, wfpw_queue
// and wfpw_back. The back end retires a request in its idle state for set window, skip, 8-bit
// writes and out-of-range accesses, via a low-byte state for 16-bit writes and via wait and
// finish states for 1-bit writes and byte reads, one request at a time on the single store port.
// Reset initialises the control state and starts a clearing pass that zeroes the frame store;
// req_stall stays high during it, configuration writes are taken as ever.
`default_nettype none

module windowed_framebuffer_pixel_writer_unit #(
	parameter int MAX_COLUMNS = wfpw_pkg::MAX_COLUMNS_DEF,
	parameter int MAX_ROWS    = wfpw_pkg::MAX_ROWS_DEF,
	parameter int STORE_BYTES = wfpw_pkg::STORE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  kind,
	input  logic [7:0]  x_start,
	input  logic [7:0]  x_end,
	input  logic [7:0]  y_start,
	input  logic [7:0]  y_end,
	input  logic [15:0] pixel_color,
	input  logic [13:0] byte_address,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [7:0]  read_data,
	output logic [6:0]  next_x,
	output logic [5:0]  next_y,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_data
);

	import wfpw_pkg::*;

	q_entry_t  push_entry, head;
	q_status_t q_stat;
	logic      push, pop, clear_busy;

	wfpw_front #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.MAX_ROWS    (MAX_ROWS),
		.STORE_BYTES (STORE_BYTES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.kind         (kind),
		.x_start      (x_start),
		.x_end        (x_end),
		.y_start      (y_start),
		.y_end        (y_end),
		.pixel_color  (pixel_color),
		.byte_address (byte_address),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.q_stat       (q_stat),
		.clear_busy   (clear_busy),
		.push         (push),
		.entry        (push_entry)
	);

	wfpw_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.entry_in (push_entry),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	wfpw_back #(
		.STORE_BYTES (STORE_BYTES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.q_stat     (q_stat),
		.pop        (pop),
		.clear_busy (clear_busy),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.read_data  (read_data),
		.next_x     (next_x),
		.next_y     (next_y)
	);

endmodule

`default_nettype wire

@@ hdl/wfpw_ram.sv @@
// Generic single-port RAM with registered read data.
// Width and depth are parameters; no package dependency.
`default_nettype none

module wfpw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

@@ hdl/wfpw_front.sv @@
// Front end: configuration registers, window and cursor state, request classification.
// Forms store addresses and byte data for each request and pushes them to the queue.
// Depends on wfpw_pkg.
`default_nettype none

module wfpw_front #(
	parameter int MAX_COLUMNS = wfpw_pkg::MAX_COLUMNS_DEF,
	parameter int MAX_ROWS    = wfpw_pkg::MAX_ROWS_DEF,
	parameter int STORE_BYTES = wfpw_pkg::STORE_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  logic [1:0]          kind,
	input  logic [7:0]          x_start,
	input  logic [7:0]          x_end,
	input  logic [7:0]          y_start,
	input  logic [7:0]          y_end,
	input  logic [15:0]         pixel_color,
	input  logic [13:0]         byte_address,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [6:0]          cfg_data,
	input  wfpw_pkg::q_status_t q_stat,
	input  logic                clear_busy,
	output logic                push,
	output wfpw_pkg::q_entry_t  entry
);

	import wfpw_pkg::*;

	localparam logic [7:0]  XCap       = 8'(MAX_COLUMNS - 1);
	localparam logic [7:0]  YCap       = 8'(MAX_ROWS - 1);
	localparam logic [17:0] StoreLimit = 18'(STORE_BYTES);

	logic [1:0] depth_q;
	logic [6:0] x_last_q;
	logic [5:0] y_last_q;
	logic [6:0] col_q, col_lo_q, col_hi_q;
	logic [5:0] row_q, row_lo_q, row_hi_q;

	logic [7:0]  lim_x_w, lim_y_w, span;
	logic [6:0]  lim_x, xs, xe, adv_col;
	logic [5:0]  lim_y, ys, ye, adv_row, mul_row;
	logic [7:0]  col_inc;
	logic [6:0]  row_inc;
	logic [13:0] prod;
	logic [14:0] base;
	logic [15:0] pix_addr;
	logic        en_lo, en_hi, rd_ok, accept;

	assign lim_x_w = ({1'b0, x_last_q} > XCap) ? XCap : {1'b0, x_last_q};
	assign lim_y_w = ({2'b00, y_last_q} > YCap) ? YCap : {2'b00, y_last_q};
	assign lim_x   = lim_x_w[6:0];
	assign lim_y   = lim_y_w[5:0];
	assign span    = {1'b0, lim_x} + 8'd1;

	assign xs = (x_start > {1'b0, lim_x}) ? lim_x : x_start[6:0];
	assign xe = (x_end > {1'b0, lim_x}) ? lim_x : x_end[6:0];
	assign ys = (y_start > {2'b00, lim_y}) ? lim_y : y_start[5:0];
	assign ye = (y_end > {2'b00, lim_y}) ? lim_y : y_end[5:0];

	assign col_inc = {1'b0, col_q} + 8'd1;
	assign row_inc = {1'b0, row_q} + 7'd1;

	always_comb begin
		if (col_inc > {1'b0, col_hi_q}) begin
			adv_col = col_lo_q;
			adv_row = (row_inc >= {1'b0, row_hi_q}) ? row_lo_q : row_inc[5:0];
		end else begin
			adv_col = col_inc[6:0];
			adv_row = row_q;
		end
	end

	// In paged one-bit mode a byte holds a column of eight rows.
	assign mul_row  = (depth_q == DEPTH_1BIT) ? {3'b000, row_q[5:3]} : row_q;
	assign prod     = {8'b0, mul_row} * {6'b0, span};
	assign base     = {1'b0, prod} + {8'b0, col_q};
	assign pix_addr = (depth_q == DEPTH_16BIT) ? {base, 1'b0} : {1'b0, base};
	assign en_lo    = {2'b00, pix_addr} < StoreLimit;
	assign en_hi    = ({2'b00, pix_addr} + 18'd1) < StoreLimit;
	assign rd_ok    = {4'b0, byte_address} < StoreLimit;

	always_comb begin
		entry         = '0;
		entry.op      = OP_NONE;
		entry.addr    = pix_addr;
		entry.data0   = pixel_color[7:0];
		entry.data1   = pixel_color[7:0];
		entry.en1     = en_hi;
		entry.bit_set = |pixel_color;
		entry.next_x  = col_q;
		entry.next_y  = row_q;
		case (kind)
			KIND_SET_WINDOW: begin
				entry.next_x = xs;
				entry.next_y = ys;
			end
			KIND_WRITE: begin
				entry.next_x = adv_col;
				entry.next_y = adv_row;
				case (depth_q)
					DEPTH_16BIT: begin
						entry.op    = en_lo ? OP_PAIR : OP_NONE;
						entry.data0 = pixel_color[15:8];
						entry.data1 = pixel_color[7:0];
					end
					DEPTH_8BIT: begin
						entry.op = en_lo ? OP_BYTE : OP_NONE;
					end
					DEPTH_1BIT: begin
						entry.op    = en_lo ? OP_BIT : OP_NONE;
						entry.data0 = 8'b1 << row_q[2:0];
					end
					default: begin
						entry.op = OP_NONE;
					end
				endcase
			end
			KIND_SKIP: begin
				entry.next_x = adv_col;
				entry.next_y = adv_row;
			end
			KIND_READ: begin
				entry.addr = {2'b00, byte_address};
				entry.op   = rd_ok ? OP_READ : OP_NONE;
			end
			default: begin
				entry.op = OP_NONE;
			end
		endcase
	end

	assign req_stall = q_stat.full || clear_busy;
	assign accept    = req_valid && !req_stall;
	assign push      = accept;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q  <= PIXEL_DEPTH_RST;
			x_last_q <= X_LAST_RST;
			y_last_q <= Y_LAST_RST;
			col_q    <= '0;
			row_q    <= '0;
			col_lo_q <= '0;
			col_hi_q <= '0;
			row_lo_q <= '0;
			row_hi_q <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_PIXEL_DEPTH: depth_q  <= cfg_data[1:0];
					REG_X_LAST:      x_last_q <= cfg_data;
					REG_Y_LAST:      y_last_q <= cfg_data[5:0];
					default: begin
					end
				endcase
			end
			if (accept) begin
				col_q <= entry.next_x;
				row_q <= entry.next_y;
				if (kind == KIND_SET_WINDOW) begin
					col_lo_q <= xs;
					col_hi_q <= xe;
					row_lo_q <= ys;
					row_hi_q <= ye;
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/wfpw_queue.sv @@
// Short request queue between the front end and the back end.
// Register-based ring buffer of classified store operations.
// Depends on wfpw_pkg.
`default_nettype none

module wfpw_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  wfpw_pkg::q_entry_t  entry_in,
	input  logic                pop,
	output wfpw_pkg::q_entry_t  head,
	output wfpw_pkg::q_status_t q_stat
);

	import wfpw_pkg::*;

	localparam int Depth = QUEUE_DEPTH;
	localparam int PW    = $clog2(Depth);

	q_entry_t      slots [Depth];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PW:0]   count_q;

	assign head         = slots[rd_ptr_q];
	assign q_stat.full  = (count_q == (PW + 1)'(Depth));
	assign q_stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			slots[wr_ptr_q] <= entry_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |-> !q_stat.full)
		else $error("request pushed into a full queue");

endmodule

`default_nettype wire

@@ hdl/wfpw_back.sv @@
// Back end: executes queued store operations on the frame store and returns results.
// Runs the clearing pass after reset and owns the frame store RAM and the result register.
// Depends on wfpw_pkg and wfpw_ram.
`default_nettype none

module wfpw_back #(
	parameter int STORE_BYTES = wfpw_pkg::STORE_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  wfpw_pkg::q_entry_t  head,
	input  wfpw_pkg::q_status_t q_stat,
	output logic                pop,
	output logic                clear_busy,
	output logic                res_valid,
	input  logic                res_stall,
	output logic [7:0]          read_data,
	output logic [6:0]          next_x,
	output logic [5:0]          next_y
);

	import wfpw_pkg::*;

	localparam int AW = $clog2(STORE_BYTES);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOW,
		ST_WAIT,
		ST_FIN
	} state_t;

	state_t        state_q;
	logic [AW-1:0] clr_q;
	logic [7:0]    data_q;
	logic          res_valid_q;
	logic [7:0]    read_data_q;
	logic [6:0]    next_x_q;
	logic [5:0]    next_y_q;

	logic          ram_we, slot_free;
	logic [AW-1:0] ram_addr;
	logic [7:0]    ram_wdata, ram_rdata;

	wfpw_ram #(
		.WIDTH(8),
		.DEPTH(STORE_BYTES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign slot_free  = !res_valid_q || !res_stall;
	assign clear_busy = (state_q == ST_CLEAR);
	assign res_valid  = res_valid_q;
	assign read_data  = read_data_q;
	assign next_x     = next_x_q;
	assign next_y     = next_y_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = AW'(head.addr);
		ram_wdata = head.data0;
		pop       = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_addr  = clr_q;
				ram_wdata = 8'd0;
			end
			ST_IDLE: begin
				if (!q_stat.empty) begin
					case (head.op)
						OP_NONE: begin
							pop = slot_free;
						end
						OP_BYTE: begin
							ram_we = slot_free;
							pop    = slot_free;
						end
						OP_PAIR: begin
							ram_we = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			ST_LOW: begin
				ram_addr  = AW'(head.addr + 1'b1);
				ram_wdata = head.data1;
				ram_we    = slot_free && head.en1;
				pop       = slot_free;
			end
			ST_FIN: begin
				pop       = slot_free;
				ram_we    = slot_free && (head.op == OP_BIT);
				ram_wdata = head.bit_set ? (data_q | head.data0) : (data_q & ~head.data0);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			data_q      <= '0;
			res_valid_q <= 1'b0;
			read_data_q <= '0;
			next_x_q    <= '0;
			next_y_q    <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (clr_q == AW'(STORE_BYTES - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (!q_stat.empty) begin
						if (head.op == OP_PAIR) begin
							state_q <= ST_LOW;
						end else if (head.op inside {OP_BIT, OP_READ}) begin
							state_q <= ST_WAIT;
						end
					end
				end
				ST_LOW: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_WAIT: begin
					data_q  <= ram_rdata;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (pop) begin
				res_valid_q <= 1'b1;
				read_data_q <= (head.op == OP_READ) ? data_q : 8'd0;
				next_x_q    <= head.next_x;
				next_y_q    <= head.next_y;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("queue popped while empty");

	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		clear_busy |-> (!pop && !res_valid_q))
		else $error("request retired during the clearing pass");

	a_result_from_pop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(pop))
		else $error("result shown without a retired request");

	a_fin_write_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && state_q == ST_FIN) |-> (head.op == OP_BIT))
		else $error("read-modify-write issued for a request that is not a bit write");

endmodule

`default_nettype wire

@@ bench/tb_windowed_framebuffer_pixel_writer_unit.sv @@
`timescale 1ns / 1ps
// Testbench for windowed_framebuffer_pixel_writer_unit: directed and random pixel requests,
// checked against a frame store and cursor model kept inside this bench.
// Depends on wfpw_pkg and the block's RTL; needs no other file.

module tb_windowed_framebuffer_pixel_writer_unit;
	import wfpw_pkg::*;

	localparam logic [1:0] DEPTH_UNUSED = 2'd3;
	localparam int GRAM_BYTES = STORE_BYTES_DEF;
	localparam int CYCLE_LIMIT = 600000;

	typedef struct {
		logic [1:0]  kind;
		logic [7:0]  xs, xe, ys, ye;
		logic [15:0] color;
		logic [13:0] addr;
	} pixel_request_t;

	typedef struct packed {
		logic [7:0] rd;
		logic [6:0] nx;
		logic [5:0] ny;
	} pixel_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic [1:0]  kind = '0;
	logic [7:0]  x_start = '0;
	logic [7:0]  x_end = '0;
	logic [7:0]  y_start = '0;
	logic [7:0]  y_end = '0;
	logic [15:0] pixel_color = '0;
	logic [13:0] byte_address = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic [7:0]  read_data;
	logic [6:0]  next_x;
	logic [5:0]  next_y;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [6:0]  cfg_data = '0;

	windowed_framebuffer_pixel_writer_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.kind(kind), .x_start(x_start), .x_end(x_end), .y_start(y_start), .y_end(y_end),
		.pixel_color(pixel_color), .byte_address(byte_address),
		.res_valid(res_valid), .res_stall(res_stall),
		.read_data(read_data), .next_x(next_x), .next_y(next_y),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Model state: frame store, cursor, window and the three registers.
	logic [7:0] gram [GRAM_BYTES];
	logic [6:0] col, col_lo, col_hi;
	logic [5:0] row, row_lo, row_hi;
	logic [1:0] depth_reg = PIXEL_DEPTH_RST;
	logic [6:0] x_last_reg = X_LAST_RST;
	logic [5:0] y_last_reg = Y_LAST_RST;

	pixel_request_t request_q[$];
	pixel_result_t  cursor_byte_q[$];
	pixel_request_t on_bus;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatch_count = 0;
	int cycle_count = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void step_cursor();
		int unsigned c, rw;
		c = col + 1;
		if (c > col_hi) begin
			rw = row + 1;
			c = col_lo;
			if (rw >= row_hi)
				rw = row_lo;
			row = rw[5:0];
		end
		col = c[6:0];
	endfunction

	function automatic pixel_result_t gram_step(input pixel_request_t r);
		int unsigned xl, yl, span, a;
		pixel_result_t res;
		res.rd = 8'd0;
		xl = (x_last_reg > MAX_COLUMNS_DEF - 1) ? MAX_COLUMNS_DEF - 1 : x_last_reg;
		yl = (y_last_reg > MAX_ROWS_DEF - 1) ? MAX_ROWS_DEF - 1 : y_last_reg;
		span = xl + 1;
		case (r.kind)
		KIND_SET_WINDOW: begin
			col_lo = 7'((r.xs > xl) ? xl : r.xs);
			col_hi = 7'((r.xe > xl) ? xl : r.xe);
			row_lo = 6'((r.ys > yl) ? yl : r.ys);
			row_hi = 6'((r.ye > yl) ? yl : r.ye);
			col = col_lo;
			row = row_lo;
		end
		KIND_WRITE: begin
			if (depth_reg == DEPTH_16BIT) begin
				a = (row * span + col) * 2;
				if (a < GRAM_BYTES)
					gram[a] = r.color[15:8];
				if (a + 1 < GRAM_BYTES)
					gram[a + 1] = r.color[7:0];
			end else if (depth_reg == DEPTH_8BIT) begin
				a = row * span + col;
				if (a < GRAM_BYTES)
					gram[a] = r.color[7:0];
			end else if (depth_reg == DEPTH_1BIT) begin
				a = col + (row / 8) * span;
				if (a < GRAM_BYTES)
					gram[a][row % 8] = (r.color != 16'd0);
			end
			step_cursor();
		end
		KIND_SKIP: begin
			step_cursor();
		end
		default: begin
			if (r.addr < GRAM_BYTES)
				res.rd = gram[r.addr];
		end
		endcase
		res.nx = col;
		res.ny = row;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			kind <= '0;
			x_start <= '0;
			x_end <= '0;
			y_start <= '0;
			y_end <= '0;
			pixel_color <= '0;
			byte_address <= '0;
		end else begin
			if (req_valid && !req_stall)
				cursor_byte_q.push_back(gram_step(on_bus));
			if (!req_valid || !req_stall) begin
				if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					on_bus = request_q.pop_front();
					req_valid <= 1'b1;
					kind <= on_bus.kind;
					x_start <= on_bus.xs;
					x_end <= on_bus.xe;
					y_start <= on_bus.ys;
					y_end <= on_bus.ye;
					pixel_color <= on_bus.color;
					byte_address <= on_bus.addr;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		pixel_result_t want;
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (res_valid && !res_stall) begin
				if (cursor_byte_q.size() == 0) begin
					if (mismatch_count < 10)
						$display("Result with no request outstanding: rd=%h x=%0d y=%0d",
							read_data, next_x, next_y);
					mismatch_count++;
				end else begin
					want = cursor_byte_q.pop_front();
					if (read_data !== want.rd || next_x !== want.nx || next_y !== want.ny) begin
						if (mismatch_count < 10)
							$display("Mismatch: expected rd=%h x=%0d y=%0d, got rd=%h x=%0d y=%0d",
								want.rd, want.nx, want.ny, read_data, next_x, next_y);
						mismatch_count++;
					end
				end
			end
			res_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic pixel_request_t random_request();
		pixel_request_t r;
		r.kind = 2'($urandom_range(3));
		r.xs = 8'($urandom);
		r.xe = 8'($urandom);
		r.ys = 8'($urandom);
		r.ye = 8'($urandom);
		r.color = 16'($urandom);
		r.addr = 14'($urandom);
		return r;
	endfunction

	task automatic push_req(input logic [1:0] k, input logic [7:0] xs, xe, ys, ye,
			input logic [15:0] color, input logic [13:0] addr);
		pixel_request_t r;
		r.kind = k;
		r.xs = xs;
		r.xe = xe;
		r.ys = ys;
		r.ye = ye;
		r.color = color;
		r.addr = addr;
		request_q.push_back(r);
	endtask

	// Waits until every request has been taken and answered, then lets the pipe empty.
	task automatic settle();
		@(negedge clk);
		while (request_q.size() != 0 || req_valid || cursor_byte_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
		REG_PIXEL_DEPTH: depth_reg = val[1:0];
		REG_X_LAST:      x_last_reg = val;
		REG_Y_LAST:      y_last_reg = val[5:0];
		default: ;
		endcase
	endtask

	// Mostly a window followed by a run of writes, skips and reads near the window;
	// the rest is unstructured noise.
	task automatic queue_random(input int count);
		pixel_request_t r;
		int n, len, sel, cxs, cys, base;
		n = 0;
		while (n < count) begin
			r = random_request();
			if ($urandom_range(9) < 8) begin
				r.kind = KIND_SET_WINDOW;
				if ($urandom_range(4) != 0) begin
					r.xs = 8'($urandom_range(0, x_last_reg));
					r.xe = 8'(r.xs + $urandom_range(0, 9));
					r.ys = 8'($urandom_range(0, y_last_reg));
					r.ye = 8'(r.ys + $urandom_range(0, 6));
				end
				cxs = (r.xs > x_last_reg) ? x_last_reg : r.xs;
				cys = (r.ys > y_last_reg) ? y_last_reg : r.ys;
				if (depth_reg == DEPTH_1BIT)
					base = cxs + (cys / 8) * (x_last_reg + 1);
				else if (depth_reg == DEPTH_8BIT)
					base = cys * (x_last_reg + 1) + cxs;
				else
					base = (cys * (x_last_reg + 1) + cxs) * 2;
				request_q.push_back(r);
				n++;
				len = $urandom_range(1, 40);
				repeat (len) begin
					r = random_request();
					sel = $urandom_range(99);
					r.kind = (sel < 70) ? KIND_WRITE : (sel < 85) ? KIND_SKIP : KIND_READ;
					if (r.kind == KIND_READ && $urandom_range(1) == 1)
						r.addr = 14'((base + $urandom_range(0, 31)) % GRAM_BYTES);
					if (r.kind == KIND_WRITE && $urandom_range(3) == 0)
						r.color = 16'd0;
					request_q.push_back(r);
				end
				n += len;
			end else begin
				len = $urandom_range(1, 8);
				repeat (len)
					request_q.push_back(random_request());
				n += len;
			end
		end
	endtask

	task automatic run_phase(input logic [1:0] depth, input int xl, yl, send_pct, stall_pct,
			count);
		pixel_request_t r;
		settle();
		write_reg(REG_PIXEL_DEPTH, 7'(depth));
		write_reg(REG_X_LAST, 7'(xl));
		write_reg(REG_Y_LAST, 7'(yl));
		send_idle_pct = send_pct;
		recv_stall_pct = stall_pct;
		// A few writes with the cursor left over from the previous settings.
		repeat (3) begin
			r = random_request();
			r.kind = KIND_WRITE;
			request_q.push_back(r);
		end
		queue_random(count);
	endtask

	initial begin
		foreach (gram[i])
			gram[i] = 8'd0;
		col = '0;
		col_lo = '0;
		col_hi = '0;
		row = '0;
		row_lo = '0;
		row_hi = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Cleared store, full-screen window with clamped bounds, both bytes of 16-bit pixels.
		push_req(KIND_READ, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 14'd0);
		push_req(KIND_READ, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 14'd16383);
		push_req(KIND_SET_WINDOW, 8'd0, 8'd255, 8'd0, 8'd255, 16'h0000, 14'd0);
		push_req(KIND_WRITE, 8'd0, 8'd0, 8'd0, 8'd0, 16'hFFFF, 14'd0);
		push_req(KIND_WRITE, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0000, 14'd0);
		push_req(KIND_WRITE, 8'd0, 8'd0, 8'd0, 8'd0, 16'hA55A, 14'd0);
		push_req(KIND_SKIP, 8'd0, 8'd0, 8'd0, 8'd0, 16'h1111, 14'd0);
		push_req(KIND_READ, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0000, 14'd0);
		push_req(KIND_READ, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0000, 14'd1);
		push_req(KIND_READ, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0000, 14'd4);
		push_req(KIND_READ, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0000, 14'd5);
		// Start beyond end: the column and row wrap at once.
		push_req(KIND_SET_WINDOW, 8'd255, 8'd0, 8'd255, 8'd0, 16'h0000, 14'd0);
		push_req(KIND_WRITE, 8'd0, 8'd0, 8'd0, 8'd0, 16'h1234, 14'd0);
		push_req(KIND_SKIP, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0000, 14'd0);
		push_req(KIND_READ, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0000, 14'd16382);
		push_req(KIND_READ, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0000, 14'd16383);
		// Small window with column and row wrap.
		push_req(KIND_SET_WINDOW, 8'd2, 8'd3, 8'd5, 8'd7, 16'h0000, 14'd0);
		push_req(KIND_WRITE, 8'd0, 8'd0, 8'd0, 8'd0, 16'h8001, 14'd0);
		push_req(KIND_WRITE, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0102, 14'd0);
		push_req(KIND_WRITE, 8'd0, 8'd0, 8'd0, 8'd0, 16'h7F7F, 14'd0);
		push_req(KIND_WRITE, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0203, 14'd0);
		push_req(KIND_SKIP, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0000, 14'd0);
		push_req(KIND_READ, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0000, 14'd1284);
		push_req(KIND_READ, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0000, 14'd1285);

		run_phase(DEPTH_16BIT, 127, 63, 0, 0, 200);
		run_phase(DEPTH_8BIT, 127, 63, 72, 0, 200);
		run_phase(DEPTH_1BIT, 127, 63, 0, 72, 200);
		run_phase(DEPTH_UNUSED, 127, 63, 16, 16, 100);
		run_phase(DEPTH_16BIT, 0, 0, 0, 0, 150);
		run_phase(DEPTH_1BIT, $urandom_range(1, 20), $urandom_range(8, 40), 72, 0, 200);
		run_phase(DEPTH_8BIT, $urandom_range(20, 126), $urandom_range(1, 62), 0, 72, 200);
		run_phase(DEPTH_16BIT, 63, 31, 16, 16, 200);
		run_phase(DEPTH_1BIT, 127, 0, 16, 16, 150);
		run_phase(DEPTH_8BIT, 0, 63, 0, 0, 150);
		settle();

		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ files.f @@
hdl/wfpw_pkg.sv
hdl/wfpw_ram.sv
hdl/wfpw_front.sv
hdl/wfpw_queue.sv
hdl/wfpw_back.sv
hdl/windowed_framebuffer_pixel_writer_unit.sv
bench/tb_windowed_framebuffer_pixel_writer_unit.sv
